FILE: hw/rtl/bgi_pkg.sv
package bgi_pkg;

    localparam int VALUE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int DIFF_W   = 33;
    localparam int HPROD_W  = 48;
    localparam int POS_W    = 49;
    localparam int IDX_W    = 33;
    localparam int WEIGHT_W = 17;
    localparam int WPROD_W  = 33;
    localparam int ACC_W    = 66;
    localparam int RVAL_W   = 34;
    localparam int SIZE_W   = 7;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    localparam int CFG_INDEX_W = 3;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [WPROD_W-1:0]  wprod_t;

    localparam weight_t WEIGHT_ONE = 17'h10000;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 66'sh80000000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_ORIGIN     = 3'd0,
        CFG_Y_ORIGIN     = 3'd1,
        CFG_X_STEP_RECIP = 3'd2,
        CFG_Y_STEP_RECIP = 3'd3,
        CFG_COLS_USED    = 3'd4,
        CFG_ROWS_USED    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      oob;
        logic                      last;
    } result_t;

endpackage

FILE: hw/rtl/bilinear_grid_interpolator_top.sv
// Channel   Direction  Handshake         Beat contents
// s_        in         s_valid/s_ready   mode, load position and sample, query point, last
// m_        out        m_valid/m_ready   interpolated value, out-of-domain flag, batch last
// cfg_      in         cfg_we            register index and write data, no wait
//
// A query holds the issue stage while it reads its four corners in turn through the
// single read port of the grid memory; a load or an out-of-domain query leaves it once fired.
// Reset clears control state only; the grid memory holds nothing valid until loaded.
// Results wait in a four-entry queue while m_ready is low; the issue stage stops starting
// queries once that queue is committed, and s_ready falls while the issue stage is held.
module bilinear_grid_interpolator_top #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_mode,
    input  logic        [5:0]                      s_load_col,
    input  logic        [5:0]                      s_load_row,
    input  logic signed [bgi_pkg::VALUE_W-1:0]     s_sample_value,
    input  logic signed [bgi_pkg::VALUE_W-1:0]     s_query_x,
    input  logic signed [bgi_pkg::VALUE_W-1:0]     s_query_y,
    input  logic                                   s_last_query,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bgi_pkg::VALUE_W-1:0]     m_interp_value,
    output logic                                   m_out_of_domain,
    output logic                                   m_batch_last,

    input  logic                                   cfg_we,
    input  logic        [bgi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [bgi_pkg::VALUE_W-1:0]     cfg_wdata
);

    localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW  = $clog2(GRID_DEPTH);
    localparam int CXW = $clog2(MAX_COLS);
    localparam int CYW = $clog2(MAX_ROWS);
    localparam int LCW = ($clog2(MAX_COLS + 1) > 6) ? $clog2(MAX_COLS + 1) : 6;
    localparam int LRW = ($clog2(MAX_ROWS + 1) > 6) ? $clog2(MAX_ROWS + 1) : 6;

    // Configuration registers.
    logic signed [bgi_pkg::VALUE_W-1:0] x_origin_reg;
    logic signed [bgi_pkg::VALUE_W-1:0] y_origin_reg;
    logic        [bgi_pkg::VALUE_W-1:0] x_step_recip_reg;
    logic        [bgi_pkg::VALUE_W-1:0] y_step_recip_reg;
    logic        [bgi_pkg::SIZE_W-1:0]  cols_used_reg;
    logic        [bgi_pkg::SIZE_W-1:0]  rows_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg     <= '0;
            y_origin_reg     <= '0;
            x_step_recip_reg <= 32'h0001_0000;
            y_step_recip_reg <= 32'h0001_0000;
            cols_used_reg    <= 7'd64;
            rows_used_reg    <= 7'd64;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bgi_pkg::CFG_X_ORIGIN:     x_origin_reg     <= cfg_wdata;
                bgi_pkg::CFG_Y_ORIGIN:     y_origin_reg     <= cfg_wdata;
                bgi_pkg::CFG_X_STEP_RECIP: x_step_recip_reg <= cfg_wdata;
                bgi_pkg::CFG_Y_STEP_RECIP: y_step_recip_reg <= cfg_wdata;
                bgi_pkg::CFG_COLS_USED:    cols_used_reg    <= cfg_wdata[bgi_pkg::SIZE_W-1:0];
                bgi_pkg::CFG_ROWS_USED:    rows_used_reg    <= cfg_wdata[bgi_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front pipeline: three stages of coordinate mapping, then the issue stage.
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic mode1_reg, mode2_reg, mode3_reg, mode4_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg;
    logic lok1_reg, lok2_reg, lok3_reg, lok4_reg;
    logic [AW-1:0] laddr1_reg, laddr2_reg, laddr3_reg, laddr4_reg;
    logic signed [bgi_pkg::VALUE_W-1:0] smp1_reg, smp2_reg, smp3_reg, smp4_reg;

    logic              x_oob, y_oob;
    logic [CXW-1:0]    cell_x;
    logic [CYW-1:0]    cell_y;
    bgi_pkg::weight_t  wx, wy;

    logic              oob4_reg;
    logic [AW-1:0]     base4_reg;
    bgi_pkg::wprod_t   wq4_reg [4];

    logic [33:0]       wp00, wp10, wp01, wp11;
    bgi_pkg::weight_t  wx_lo, wy_lo;

    assign s_ready = adv;

    bgi_axis #(.MAX_N(MAX_COLS)) u_axis_x (
        .aclk     (aclk),
        .en       (adv),
        .coord    (s_query_x),
        .origin   (x_origin_reg),
        .recip    (x_step_recip_reg),
        .n_used   (cols_used_reg),
        .oob      (x_oob),
        .cell_idx (cell_x),
        .weight   (wx)
    );

    bgi_axis #(.MAX_N(MAX_ROWS)) u_axis_y (
        .aclk     (aclk),
        .en       (adv),
        .coord    (s_query_y),
        .origin   (y_origin_reg),
        .recip    (y_step_recip_reg),
        .n_used   (rows_used_reg),
        .oob      (y_oob),
        .cell_idx (cell_y),
        .weight   (wy)
    );

    always_comb begin
        wx_lo = bgi_pkg::WEIGHT_ONE - wx;
        wy_lo = bgi_pkg::WEIGHT_ONE - wy;
        wp00  = wx_lo * wy_lo;
        wp10  = wx * wy_lo;
        wp01  = wx_lo * wy;
        wp11  = wx * wy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode1_reg  <= s_mode;
            last1_reg  <= s_last_query;
            lok1_reg   <= (LCW'(s_load_col) < LCW'(MAX_COLS))
                       && (LRW'(s_load_row) < LRW'(MAX_ROWS));
            laddr1_reg <= AW'(s_load_row) * AW'(MAX_COLS) + AW'(s_load_col);
            smp1_reg   <= s_sample_value;

            mode2_reg  <= mode1_reg;
            last2_reg  <= last1_reg;
            lok2_reg   <= lok1_reg;
            laddr2_reg <= laddr1_reg;
            smp2_reg   <= smp1_reg;

            mode3_reg  <= mode2_reg;
            last3_reg  <= last2_reg;
            lok3_reg   <= lok2_reg;
            laddr3_reg <= laddr2_reg;
            smp3_reg   <= smp2_reg;

            mode4_reg  <= mode3_reg;
            last4_reg  <= last3_reg;
            lok4_reg   <= lok3_reg;
            laddr4_reg <= laddr3_reg;
            smp4_reg   <= smp3_reg;
            oob4_reg   <= x_oob || y_oob;
            base4_reg  <= AW'(cell_y) * AW'(MAX_COLS) + AW'(cell_x);
            wq4_reg[0] <= wp00[bgi_pkg::WPROD_W-1:0];
            wq4_reg[1] <= wp10[bgi_pkg::WPROD_W-1:0];
            wq4_reg[2] <= wp01[bgi_pkg::WPROD_W-1:0];
            wq4_reg[3] <= wp11[bgi_pkg::WPROD_W-1:0];
        end
    end

    // Issue stage: corner sequencer and result credits.
    logic [1:0]                   corner_reg, corner_next;
    logic [bgi_pkg::RQ_CNT_W-1:0] pend_reg, pend_next;
    logic                         need_credit, credit_ok, fire, beat, p4_done, reserve;
    logic                         grid_we;
    logic [AW-1:0]                raddr;
    logic                         out_pop;

    always_comb begin
        need_credit = mode4_reg && (corner_reg == 2'd0);
        credit_ok   = (pend_reg < bgi_pkg::RQ_CNT_W'(bgi_pkg::RQ_DEPTH));
        fire        = v4_reg && (!need_credit || credit_ok);
        beat        = fire && mode4_reg;
        reserve     = beat && (corner_reg == 2'd0);
        p4_done     = fire && (!mode4_reg || oob4_reg || (corner_reg == 2'd3));
        adv         = !v4_reg || p4_done;
        grid_we     = fire && !mode4_reg && lok4_reg;
        raddr       = base4_reg + AW'(corner_reg[0])
                    + (corner_reg[1] ? AW'(MAX_COLS) : AW'(0));
        corner_next = corner_reg;
        if (beat && !oob4_reg) begin
            corner_next = corner_reg + 2'd1;
        end
        pend_next = pend_reg + bgi_pkg::RQ_CNT_W'(reserve) - bgi_pkg::RQ_CNT_W'(out_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= 2'd0;
            pend_reg   <= '0;
        end else begin
            corner_reg <= corner_next;
            pend_reg   <= pend_next;
        end
    end

    // Grid memory: one write port for loads, one registered read port for corners.
    logic [bgi_pkg::VALUE_W-1:0] grid_mem [GRID_DEPTH];
    logic [bgi_pkg::VALUE_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[laddr4_reg] <= smp4_reg;
        end
        rd_reg <= grid_mem[raddr];
    end

    // Blend pipeline: read, multiply by corner weight, accumulate, round, saturate (zero if out of domain).
    logic                              b1_v_reg, b2_v_reg, done_reg;
    logic                              b1_first_reg, b1_fin_reg, b1_oob_reg, b1_last_reg;
    logic                              b2_first_reg, b2_fin_reg, b2_oob_reg, b2_last_reg;
    logic                              b3_oob_reg, b3_last_reg;
    bgi_pkg::wprod_t                   b1_w_reg;
    logic signed [bgi_pkg::ACC_W-1:0]  prod_reg;
    logic signed [bgi_pkg::ACC_W-1:0]  acc_reg, acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            b1_v_reg <= beat;
            b2_v_reg <= b1_v_reg;
            done_reg <= b2_v_reg && b2_fin_reg;
        end
    end

    always_comb begin
        acc_next = (b2_first_reg ? bgi_pkg::ROUND_BIAS : acc_reg) + prod_reg;
    end

    always_ff @(posedge aclk) begin
        b1_first_reg <= (corner_reg == 2'd0);
        b1_fin_reg   <= oob4_reg || (corner_reg == 2'd3);
        b1_oob_reg   <= oob4_reg;
        b1_last_reg  <= last4_reg;
        b1_w_reg     <= wq4_reg[corner_reg];

        b2_first_reg <= b1_first_reg;
        b2_fin_reg   <= b1_fin_reg;
        b2_oob_reg   <= b1_oob_reg;
        b2_last_reg  <= b1_last_reg;
        prod_reg     <= $signed(rd_reg) * $signed({1'b0, b1_w_reg});

        if (b2_v_reg) begin
            acc_reg <= acc_next;
        end
        if (b2_v_reg && b2_fin_reg) begin
            b3_oob_reg  <= b2_oob_reg;
            b3_last_reg <= b2_last_reg;
        end
    end

    logic signed [bgi_pkg::RVAL_W-1:0] rval;
    bgi_pkg::result_t                  res;
    bgi_pkg::result_t                  out_res;

    always_comb begin
        rval = acc_reg[bgi_pkg::ACC_W-1:32];
        if (b3_oob_reg) begin
            res.value = '0;
        end else if (rval > bgi_pkg::RVAL_W'(bgi_pkg::VALUE_MAX)) begin
            res.value = bgi_pkg::VALUE_MAX;
        end else if (rval < $signed(bgi_pkg::RVAL_W'(bgi_pkg::VALUE_MIN))) begin
            res.value = bgi_pkg::VALUE_MIN;
        end else begin
            res.value = rval[bgi_pkg::VALUE_W-1:0];
        end
        res.oob  = b3_oob_reg;
        res.last = b3_last_reg;
    end

    bgi_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (done_reg),
        .push_data (res),
        .pop_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_res)
    );

    assign out_pop         = m_valid && m_ready;
    assign m_interp_value  = out_res.value;
    assign m_out_of_domain = out_res.oob;
    assign m_batch_last    = out_res.last;

endmodule

FILE: hw/rtl/bgi_axis.sv
module bgi_axis #(
    parameter int MAX_N = 64
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [bgi_pkg::VALUE_W-1:0]   coord,
    input  logic signed [bgi_pkg::VALUE_W-1:0]   origin,
    input  logic        [bgi_pkg::VALUE_W-1:0]   recip,
    input  logic        [bgi_pkg::SIZE_W-1:0]    n_used,
    output logic                                 oob,
    output logic        [$clog2(MAX_N)-1:0]      cell_idx,
    output bgi_pkg::weight_t                     weight
);

    localparam int CW = $clog2(MAX_N);
    localparam int NW = $clog2(MAX_N + 1);
    localparam int SW = (NW > bgi_pkg::SIZE_W) ? NW : bgi_pkg::SIZE_W;

    logic signed [bgi_pkg::DIFF_W-1:0]  d_reg;
    logic                               neg_reg;
    logic                               rzero_reg;
    logic        [bgi_pkg::HPROD_W-1:0] hx_reg;
    logic        [bgi_pkg::HPROD_W-1:0] lx_reg;
    logic                               oob_reg;
    logic        [CW-1:0]               cell_reg;
    bgi_pkg::weight_t                   weight_reg;

    logic        [SW-1:0]               n_ext;
    logic        [SW-1:0]               n_sat;
    logic        [NW-1:0]               n_lim;
    logic        [NW-1:0]               nm1;
    logic        [bgi_pkg::POS_W-1:0]   pos;
    logic        [bgi_pkg::IDX_W-1:0]   idx;
    logic        [bgi_pkg::FRAC_W-1:0]  fr;
    logic                               oob_next;
    logic        [CW-1:0]               cell_next;
    bgi_pkg::weight_t                   weight_next;

    always_comb begin
        n_ext = SW'(n_used);
        if (n_ext < SW'(2)) begin
            n_sat = SW'(2);
        end else if (n_ext > SW'(MAX_N)) begin
            n_sat = SW'(MAX_N);
        end else begin
            n_sat = n_ext;
        end
        n_lim = NW'(n_sat);
        nm1   = n_lim - NW'(1);
    end

    always_comb begin
        if (neg_reg) begin
            pos = '0;
        end else begin
            pos = {1'b0, hx_reg} + bgi_pkg::POS_W'(lx_reg[bgi_pkg::HPROD_W-1:bgi_pkg::FRAC_W]);
        end
        idx = pos[bgi_pkg::POS_W-1:bgi_pkg::FRAC_W];
        fr  = pos[bgi_pkg::FRAC_W-1:0];

        oob_next    = 1'b0;
        cell_next   = CW'(idx);
        weight_next = {1'b0, fr};
        if (neg_reg && !rzero_reg) begin
            oob_next = 1'b1;
        end else if (idx > bgi_pkg::IDX_W'(nm1)) begin
            oob_next = 1'b1;
        end else if (idx == bgi_pkg::IDX_W'(nm1)) begin
            oob_next    = (fr != '0);
            cell_next   = CW'(n_lim - NW'(2));
            weight_next = bgi_pkg::WEIGHT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg      <= {coord[bgi_pkg::VALUE_W-1], coord}
                        - {origin[bgi_pkg::VALUE_W-1], origin};
            neg_reg    <= d_reg[bgi_pkg::DIFF_W-1];
            rzero_reg  <= (recip == '0);
            hx_reg     <= d_reg[31:16] * recip;
            lx_reg     <= d_reg[15:0] * recip;
            oob_reg    <= oob_next;
            cell_reg   <= cell_next;
            weight_reg <= weight_next;
        end
    end

    assign oob      = oob_reg;
    assign cell_idx = cell_reg;
    assign weight   = weight_reg;

endmodule

FILE: hw/rtl/bgi_result_fifo.sv
module bgi_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bgi_pkg::result_t  push_data,
    input  logic              pop_ready,
    output logic              out_valid,
    output bgi_pkg::result_t  out_data
);

    bgi_pkg::result_t                 slot_reg [bgi_pkg::RQ_DEPTH];
    logic [bgi_pkg::RQ_PTR_W-1:0]     wr_ptr_reg;
    logic [bgi_pkg::RQ_PTR_W-1:0]     rd_ptr_reg;
    logic [bgi_pkg::RQ_CNT_W-1:0]     count_reg;
    logic                             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + bgi_pkg::RQ_CNT_W'(push) - bgi_pkg::RQ_CNT_W'(pop);
        end
    end

endmodule

FILE: test/tb_bilinear_grid_interpolator_top.sv
module tb_bilinear_grid_interpolator_top;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic        mode;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [31:0] sample;
        logic [31:0] qx;
        logic [31:0] qy;
        logic        last;
    } grid_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [5:0]  s_load_col = '0;
    logic [5:0]  s_load_row = '0;
    logic signed [bgi_pkg::VALUE_W-1:0] s_sample_value = '0;
    logic signed [bgi_pkg::VALUE_W-1:0] s_query_x = '0;
    logic signed [bgi_pkg::VALUE_W-1:0] s_query_y = '0;
    logic        s_last_query = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [bgi_pkg::VALUE_W-1:0] m_interp_value;
    logic        m_out_of_domain;
    logic        m_batch_last;
    logic        cfg_we = 1'b0;
    logic [bgi_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bgi_pkg::VALUE_W-1:0]     cfg_wdata = '0;

    bilinear_grid_interpolator_top #(
        .MAX_COLS(GRID_COLS),
        .MAX_ROWS(GRID_ROWS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_load_col(s_load_col),
        .s_load_row(s_load_row),
        .s_sample_value(s_sample_value),
        .s_query_x(s_query_x),
        .s_query_y(s_query_y),
        .s_last_query(s_last_query),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_interp_value(m_interp_value),
        .m_out_of_domain(m_out_of_domain),
        .m_batch_last(m_batch_last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    logic [31:0] x_org = 32'd0;
    logic [31:0] y_org = 32'd0;
    logic [31:0] x_recip = 32'd65536;
    logic [31:0] y_recip = 32'd65536;
    logic [6:0]  cols_reg = 7'd64;
    logic [6:0]  rows_reg = 7'd64;

    logic [31:0] grid_mirror [0:GRID_COLS*GRID_ROWS-1];
    bit          loaded_cells [0:GRID_COLS*GRID_ROWS-1];

    grid_beat_t         beats_to_send [$];
    bgi_pkg::result_t   answers_due [$];
    grid_beat_t         cur_beat;
    int          send_wait = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_span(input logic [6:0] n, input int maxn);
        if (n < 2) return 2;
        if (n > maxn) return maxn;
        return int'(n);
    endfunction

    // Maps a coordinate to a cell and the weight of the upper sample.
    function automatic logic map_axis(input logic [31:0] q, input logic [31:0] org,
                                      input logic [31:0] recip, input int n,
                                      output int cell_no, output longint w);
        longint      d;
        logic [63:0] ud;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] fr;
        cell_no = 0;
        w = 0;
        d = longint'($signed(q)) - longint'($signed(org));
        if (d < 0) begin
            if (recip != 0) return 1'b0;
            p = 64'd0;
        end else begin
            ud = d;
            p = (ud >> 16) * recip + (((ud & 64'hFFFF) * recip) >> 16);
        end
        idx = p >> 16;
        fr = p & 64'hFFFF;
        if (idx > n - 1) return 1'b0;
        if (idx == n - 1) begin
            if (fr != 0) return 1'b0;
            cell_no = n - 2;
            w = 65536;
        end else begin
            cell_no = int'(idx);
            w = longint'(fr);
        end
        return 1'b1;
    endfunction

    function automatic longint corner(input int col, input int row);
        return longint'($signed(grid_mirror[row*GRID_COLS + col]));
    endfunction

    function automatic bgi_pkg::result_t interpolate_point(input grid_beat_t b);
        bgi_pkg::result_t res;
        int          cx, cy;
        longint      wx, wy, zl, zu, z, r;
        logic [63:0] u;
        res.last = b.last;
        res.oob = 1'b1;
        res.value = '0;
        if (!map_axis(b.qx, x_org, x_recip, clamp_span(cols_reg, GRID_COLS), cx, wx) ||
            !map_axis(b.qy, y_org, y_recip, clamp_span(rows_reg, GRID_ROWS), cy, wy))
            return res;
        zl = corner(cx, cy) * (65536 - wx) + corner(cx + 1, cy) * wx;
        zu = corner(cx, cy + 1) * (65536 - wx) + corner(cx + 1, cy + 1) * wx;
        z = zl * (65536 - wy) + zu * wy;
        // The blend carries 32 fractional bits beyond the sample's own; round half up back to Q16.16.
        u = z + 64'h80000000 + 64'h8000000000000000;
        r = longint'(u >> 32) - 64'sd2147483648;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        res.value = r[31:0];
        res.oob = 1'b0;
        return res;
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 511) - 256;
            default: return $urandom;
        endcase
    endfunction

    // Picks a coordinate that lands near the grid, seen through one axis setting.
    function automatic logic [31:0] pick_coord(input logic [31:0] org, input logic [31:0] recip,
                                               input int n);
        longint tp, d, qv;
        if (recip == 0) return $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: tp = longint'($urandom_range(0, n - 1)) << 16;
            3: tp = longint'(n - 1) << 16;
            4: tp = (longint'(n - 1) << 16) + longint'($urandom_range(1, 70000));
            default: tp = longint'($urandom_range(0, (n - 1) * 65536));
        endcase
        if ($urandom_range(0, 1))
            d = (tp << 16) / longint'(recip);
        else
            d = ((tp << 16) + longint'(recip) - 1) / longint'(recip);
        qv = longint'($signed(org)) + d;
        if (qv > 64'sd2147483647) return $urandom;
        return qv[31:0];
    endfunction

    task automatic add_load(input int col, input int row, input logic [31:0] value);
        grid_beat_t b;
        b.mode = 1'b0;
        b.col = 6'(col);
        b.row = 6'(row);
        b.sample = value;
        b.qx = $urandom;
        b.qy = $urandom;
        b.last = 1'($urandom_range(0, 1));
        beats_to_send.push_back(b);
        loaded_cells[row*GRID_COLS + col] = 1'b1;
    endtask

    // Loads any corner the query would read that has never been written, then the query.
    task automatic add_query(input logic [31:0] qx, input logic [31:0] qy, input logic last);
        grid_beat_t b;
        int         cx, cy;
        longint     wx, wy;
        logic       okx, oky;
        okx = map_axis(qx, x_org, x_recip, clamp_span(cols_reg, GRID_COLS), cx, wx);
        oky = map_axis(qy, y_org, y_recip, clamp_span(rows_reg, GRID_ROWS), cy, wy);
        if (okx && oky) begin
            for (int dy = 0; dy < 2; dy++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    if (!loaded_cells[(cy + dy)*GRID_COLS + cx + dx])
                        add_load(cx + dx, cy + dy, pick_sample());
                end
            end
        end
        b.mode = 1'b1;
        b.col = 6'($urandom);
        b.row = 6'($urandom);
        b.sample = $urandom;
        b.qx = qx;
        b.qy = qy;
        b.last = last;
        beats_to_send.push_back(b);
    endtask

    task automatic add_random_beats(input int count);
        int   r;
        logic last;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            last = ($urandom_range(0, 7) == 0);
            if (r < 18)
                add_load($urandom_range(0, 63), $urandom_range(0, 63), pick_sample());
            else if (r < 85)
                add_query(pick_coord(x_org, x_recip, clamp_span(cols_reg, GRID_COLS)),
                          pick_coord(y_org, y_recip, clamp_span(rows_reg, GRID_ROWS)), last);
            else
                add_query($urandom, $urandom, last);
        end
    endtask

    task automatic write_reg(input bgi_pkg::cfg_index_t idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            bgi_pkg::CFG_X_ORIGIN:     x_org = data;
            bgi_pkg::CFG_Y_ORIGIN:     y_org = data;
            bgi_pkg::CFG_X_STEP_RECIP: x_recip = data;
            bgi_pkg::CFG_Y_STEP_RECIP: y_recip = data;
            bgi_pkg::CFG_COLS_USED:    cols_reg = data[6:0];
            bgi_pkg::CFG_ROWS_USED:    rows_reg = data[6:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [31:0] xo, input logic [31:0] yo,
                                 input logic [31:0] xr, input logic [31:0] yr,
                                 input logic [6:0] nc, input logic [6:0] nr);
        logic [31:0] size_word;
        write_reg(bgi_pkg::CFG_X_ORIGIN, xo);
        write_reg(bgi_pkg::CFG_Y_ORIGIN, yo);
        write_reg(bgi_pkg::CFG_X_STEP_RECIP, xr);
        write_reg(bgi_pkg::CFG_Y_STEP_RECIP, yr);
        size_word = $urandom;
        size_word[6:0] = nc;
        write_reg(bgi_pkg::CFG_COLS_USED, size_word);
        size_word = $urandom;
        size_word[6:0] = nr;
        write_reg(bgi_pkg::CFG_ROWS_USED, size_word);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (beats_to_send.size() != 0 || s_valid || answers_due.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_origin();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 1 << 25) - (1 << 24);
    endfunction

    function automatic logic [31:0] pick_recip();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(1, 255);
            default: return $urandom_range(4096, 1 << 20);
        endcase
    endfunction

    function automatic logic [6:0] pick_span();
        case ($urandom_range(0, 9))
            0: return 7'($urandom_range(0, 1));
            1: return 7'($urandom_range(65, 127));
            2: return 7'd64;
            3: return 7'd2;
            default: return 7'($urandom_range(2, 12));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (!cur_beat.mode)
                    grid_mirror[{cur_beat.row, cur_beat.col}] = cur_beat.sample;
                else
                    answers_due.push_back(interpolate_point(cur_beat));
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    cur_beat = beats_to_send.pop_front();
                    s_mode <= cur_beat.mode;
                    s_load_col <= cur_beat.col;
                    s_load_row <= cur_beat.row;
                    s_sample_value <= cur_beat.sample;
                    s_query_x <= cur_beat.qx;
                    s_query_y <= cur_beat.qy;
                    s_last_query <= cur_beat.last;
                    s_valid <= 1'b1;
                    send_wait = gap_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        bgi_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no query waiting");
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_interp_value !== want.value) begin
                        $error("interp_value: expected %h, got %h", want.value, m_interp_value);
                        mismatches++;
                    end
                    if (m_out_of_domain !== want.oob) begin
                        $error("out_of_domain: expected %b, got %b", want.oob, m_out_of_domain);
                        mismatches++;
                    end
                    if (m_batch_last !== want.last) begin
                        $error("batch_last: expected %b, got %b", want.last, m_batch_last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_bilinear_grid_interpolator_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part under the reset setting, where one grid unit is 1.0.
        add_load(0, 0, 32'h00000001);
        add_load(1, 0, 32'h00000000);
        add_load(0, 1, 32'h7FFFFFFF);
        add_load(1, 1, 32'h80000000);
        add_load(62, 62, 32'h7FFFFFFF);
        add_load(63, 62, 32'h7FFFFFFF);
        add_load(62, 63, 32'h7FFFFFFF);
        add_load(63, 63, 32'h7FFFFFFF);
        add_query(32'h0, 32'h0, 1'b0);
        add_query(32'h8000, 32'h0, 1'b0);
        add_query(32'h8000, 32'h8000, 1'b1);
        add_query(32'h0, 32'h10000, 1'b0);
        add_query(32'd63 << 16, (32'd62 << 16) + 32'h8000, 1'b0);
        add_query(32'd63 << 16, 32'd63 << 16, 1'b0);
        add_query((32'd63 << 16) + 32'd1, 32'h0, 1'b0);
        add_query(32'hFFFFFFFF, 32'h0, 1'b0);
        add_query(32'h0, 32'd64 << 16, 1'b1);
        add_query(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        add_query(32'h80000000, 32'h80000000, 1'b1);
        add_load(0, 0, 32'hFFFFFFFF);
        add_query(32'h8000, 32'h0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_registers(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd8, 7'd8);
                1: set_registers(32'h80000000, 32'h80000000, 32'd1, 32'd1, 7'd2, 7'd2);
                2: set_registers(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                 7'd64, 7'd64);
                3: set_registers(pick_origin(), pick_origin(), 32'h0, pick_recip(),
                                 7'd1, 7'd127);
                4: set_registers(pick_origin(), pick_origin(), 32'd65536, 32'h0,
                                 7'd0, 7'd65);
                default: set_registers(pick_origin(), pick_origin(), pick_recip(),
                                       pick_recip(), pick_span(), pick_span());
            endcase
            calm = (ph % 3 == 1);
            add_random_beats(45);
            wait_drained();
        end

        if (mismatches == 0)
            $display("tb_bilinear_grid_interpolator_top: PASS");
        else
            $display("tb_bilinear_grid_interpolator_top: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bgi_pkg.sv
hw/rtl/bgi_axis.sv
hw/rtl/bgi_result_fifo.sv
hw/rtl/bilinear_grid_interpolator_top.sv
test/tb_bilinear_grid_interpolator_top.sv
